// ===== rtl/core/plf_pkg.sv =====
// Package with the codes, constants and grid helper functions of the Playfair core.
package plf_pkg;

    localparam int unsigned LETTER_W = 5;
    localparam int unsigned ACTION_W = 3;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned LETTERS  = 26;
    localparam int unsigned CELLS    = 25;
    localparam int unsigned SIDE     = 5;

    localparam logic [LETTER_W-1:0] LETTER_A = 5'd0;
    localparam logic [LETTER_W-1:0] LETTER_Q = 5'd16;
    localparam logic [LETTER_W-1:0] LETTER_X = 5'd23;
    localparam logic [LETTER_W-1:0] LETTER_Z = 5'd25;

    localparam logic [ACTION_W-1:0] ACT_START_KEY = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_KEY_LETTER = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_END_KEY = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_PLAIN = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_END_TEXT = 3'd4;

    localparam logic [KIND_W-1:0] KIND_CIPHER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACK    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FILLER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD    = 1'b1;

    localparam logic [2:0] LAST_RC = 3'd4;

    function automatic logic good_letter(input logic [LETTER_W-1:0] v);
        good_letter = (v <= LETTER_Z) && (v != LETTER_Q);
    endfunction

    // Row of a cell index, found by comparison against the row starts.
    function automatic logic [2:0] pos_row(input logic [LETTER_W-1:0] p);
        if (p >= 5'd20) begin
            pos_row = 3'd4;
        end else if (p >= 5'd15) begin
            pos_row = 3'd3;
        end else if (p >= 5'd10) begin
            pos_row = 3'd2;
        end else if (p >= 5'd5) begin
            pos_row = 3'd1;
        end else begin
            pos_row = 3'd0;
        end
    endfunction

    function automatic logic [2:0] pos_col(input logic [LETTER_W-1:0] p);
        logic [2:0]          r;
        logic [LETTER_W-1:0] d;
        r = pos_row(p);
        d = p - {r, 2'b00} - {2'b00, r};
        pos_col = d[2:0];
    endfunction

    function automatic logic [LETTER_W-1:0] cell_at(input logic [2:0] r, input logic [2:0] c);
        cell_at = {r, 2'b00} + {2'b00, r} + {2'b00, c};
    endfunction

    function automatic logic [2:0] next_rc(input logic [2:0] x);
        next_rc = (x == LAST_RC) ? 3'd0 : x + 3'd1;
    endfunction

endpackage

// ===== rtl/core/plf_ram.sv =====
// Generic single write port RAM with one registered read port.
module plf_ram #(
    parameter int unsigned WIDTH = 5,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== rtl/core/playfair_digraph_cipher_core.sv =====
// Top level of the Playfair digraph cipher core with its sequencer and grid stores.
//
// Usage: requests enter on the s_ channel (s_action, s_letter) and results leave on the
// m_ channel (m_out_letter, m_kind, m_last), both with valid/ready. The filler and pad
// letters are written through the cfg_ channel; the user must write them only while the
// core is idle, which the core does not enforce; cfg_ready is always high.
// The core takes one request at a time; s_ready is high only while the sequencer waits.
// A key letter, start key or any rejected request passes through the execute and emit
// states before its result is registered. End key walks the alphabet once, one letter a
// cycle, and acknowledges once the walk reaches z. A plain letter that completes a pair
// needs two reads of the letter position store and two reads of the grid through their
// single read ports, and the two cipher letters then leave in order from OUT1 and OUT2.
// A plain letter that is only held gives no result; the core returns to idle from execute.
// One output register parts the two sides: a new request may be accepted while a result
// still waits to be taken. When the receiver stalls, the sequencer holds at its next
// result until the output register is free, and accepts nothing meanwhile.
// Reset clears the key, the held letter and the output register, and restores the filler
// to x and the pad to z. No clearing pass runs: a key must be completed before text.
module playfair_digraph_cipher_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [plf_pkg::ACTION_W-1:0]   s_action,
    input  logic [plf_pkg::LETTER_W-1:0]   s_letter,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [plf_pkg::LETTER_W-1:0]   m_out_letter,
    output logic [plf_pkg::KIND_W-1:0]     m_kind,
    output logic                           m_last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [plf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [plf_pkg::LETTER_W-1:0]   cfg_data
);
    import plf_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_EXEC = 10'b0000000010,
        ST_FILL = 10'b0000000100,
        ST_EMIT = 10'b0000001000,
        ST_RDA  = 10'b0000010000,
        ST_RDB  = 10'b0000100000,
        ST_GRA  = 10'b0001000000,
        ST_GRB  = 10'b0010000000,
        ST_OUT1 = 10'b0100000000,
        ST_OUT2 = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [ACTION_W-1:0] act_reg, act_next;
    logic [LETTER_W-1:0] let_reg, let_next;
    logic [LETTERS-1:0]  used_reg, used_next;
    logic [LETTER_W-1:0] count_reg, count_next;
    logic                key_ready_reg, key_ready_next;
    logic [LETTER_W-1:0] pend_reg, pend_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [LETTER_W-1:0] filler_reg, filler_next;
    logic [LETTER_W-1:0] pad_reg, pad_next;
    logic [LETTER_W-1:0] walk_reg, walk_next;
    logic [LETTER_W-1:0] b_reg, b_next;
    logic [LETTER_W-1:0] p1_reg, p1_next;
    logic [LETTER_W-1:0] q2_reg, q2_next;
    logic [LETTER_W-1:0] c1_reg, c1_next;
    logic [LETTER_W-1:0] c2_reg, c2_next;
    logic [KIND_W-1:0]   res_kind_reg, res_kind_next;
    logic                res_last_reg, res_last_next;
    logic                m_valid_reg, m_valid_next;
    logic [LETTER_W-1:0] m_letter_reg, m_letter_next;
    logic [KIND_W-1:0]   m_kind_reg, m_kind_next;
    logic                m_last_reg, m_last_next;

    logic                slot_free;
    logic                emit_en;
    logic [LETTER_W-1:0] emit_letter;
    logic [KIND_W-1:0]   emit_kind;
    logic                emit_last;

    logic                wr_en;
    logic [LETTER_W-1:0] wr_letter;
    logic [LETTER_W-1:0] place_rd_addr;
    logic [LETTER_W-1:0] place_rd;
    logic [LETTER_W-1:0] grid_rd_addr;
    logic [LETTER_W-1:0] grid_rd;

    logic [LETTER_W-1:0] filler_eff;
    logic [LETTER_W-1:0] pad_eff;
    logic [2:0]          r1, c1, r2, c2;
    logic [LETTER_W-1:0] q1_calc, q2_calc;
    logic [31:0]         used_wide;

    assign s_ready      = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_out_letter = m_letter_reg;
    assign m_kind       = m_kind_reg;
    assign m_last       = m_last_reg;

    assign slot_free  = !m_valid_reg || m_ready;
    assign filler_eff = good_letter(filler_reg) ? filler_reg : LETTER_X;
    assign pad_eff    = good_letter(pad_reg) ? pad_reg : LETTER_Z;
    assign used_wide  = {6'b0, used_reg};

    // Both stores are written together: the grid cell at the fill count and the
    // position of that letter.
    plf_ram #(.WIDTH(LETTER_W), .DEPTH(CELLS)) u_grid (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg),
        .wr_data (wr_letter),
        .rd_addr (grid_rd_addr),
        .rd_data (grid_rd)
    );

    plf_ram #(.WIDTH(LETTER_W), .DEPTH(LETTERS)) u_place (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_letter),
        .wr_data (count_reg),
        .rd_addr (place_rd_addr),
        .rd_data (place_rd)
    );

    // Position arithmetic for the pair, from the first position and the second read.
    always_comb begin
        r1 = pos_row(p1_reg);
        c1 = pos_col(p1_reg);
        r2 = pos_row(place_rd);
        c2 = pos_col(place_rd);
        if (c1 == c2) begin
            q1_calc = cell_at(next_rc(r1), c1);
            q2_calc = cell_at(next_rc(r2), c2);
        end else if (r1 == r2) begin
            q1_calc = cell_at(r1, next_rc(c1));
            q2_calc = cell_at(r2, next_rc(c2));
        end else begin
            q1_calc = cell_at(r1, c2);
            q2_calc = cell_at(r2, c1);
        end
    end

    always_comb begin
        state_next      = state_reg;
        act_next        = act_reg;
        let_next        = let_reg;
        used_next       = used_reg;
        count_next      = count_reg;
        key_ready_next  = key_ready_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        filler_next     = filler_reg;
        pad_next        = pad_reg;
        walk_next       = walk_reg;
        b_next          = b_reg;
        p1_next         = p1_reg;
        q2_next         = q2_reg;
        c1_next         = c1_reg;
        c2_next         = c2_reg;
        res_kind_next   = res_kind_reg;
        res_last_next   = res_last_reg;
        wr_en           = 1'b0;
        wr_letter       = let_reg;
        place_rd_addr   = pend_reg;
        grid_rd_addr    = q2_reg;
        emit_en         = 1'b0;
        emit_letter     = LETTER_A;
        emit_kind       = KIND_ACK;
        emit_last       = 1'b0;

        if (cfg_valid) begin
            case (cfg_index)
                CFG_FILLER: begin
                    filler_next = cfg_data;
                end
                CFG_PAD: begin
                    pad_next = cfg_data;
                end
                default: begin
                end
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    act_next   = s_action;
                    let_next   = s_letter;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                res_kind_next = KIND_ERROR;
                res_last_next = 1'b0;
                state_next    = ST_EMIT;
                case (act_reg)
                    ACT_START_KEY: begin
                        used_next       = '0;
                        count_next      = '0;
                        key_ready_next  = 1'b0;
                        pend_valid_next = 1'b0;
                        res_kind_next   = KIND_ACK;
                    end
                    ACT_KEY_LETTER: begin
                        if (!key_ready_reg && good_letter(let_reg)) begin
                            res_kind_next = KIND_ACK;
                            if (!used_wide[let_reg]) begin
                                used_next = used_reg | (LETTERS'(1) << let_reg);
                                if (count_reg < LETTER_W'(CELLS)) begin
                                    wr_en      = 1'b1;
                                    count_next = count_reg + 5'd1;
                                end
                            end
                        end
                    end
                    ACT_END_KEY: begin
                        if (!key_ready_reg) begin
                            walk_next  = LETTER_A;
                            state_next = ST_FILL;
                        end
                    end
                    ACT_PLAIN: begin
                        if (key_ready_reg && good_letter(let_reg)) begin
                            res_last_next = 1'b0;
                            if (!pend_valid_reg) begin
                                pend_next       = let_reg;
                                pend_valid_next = 1'b1;
                                state_next      = ST_IDLE;
                            end else if (pend_reg == let_reg) begin
                                b_next     = filler_eff;
                                state_next = ST_RDA;
                            end else begin
                                b_next          = let_reg;
                                pend_valid_next = 1'b0;
                                state_next      = ST_RDA;
                            end
                        end
                    end
                    ACT_END_TEXT: begin
                        res_last_next = 1'b1;
                        if (key_ready_reg) begin
                            if (pend_valid_reg) begin
                                b_next          = pad_eff;
                                pend_valid_next = 1'b0;
                                state_next      = ST_RDA;
                            end else begin
                                res_kind_next = KIND_ACK;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_FILL: begin
                // One letter of the alphabet a cycle; unused ones other than q take the next cell.
                wr_letter = walk_reg;
                if (walk_reg != LETTER_Q && !used_wide[walk_reg]) begin
                    used_next = used_reg | (LETTERS'(1) << walk_reg);
                    if (count_reg < LETTER_W'(CELLS)) begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 5'd1;
                    end
                end
                walk_next = walk_reg + 5'd1;
                if (walk_reg == LETTER_Z) begin
                    key_ready_next = 1'b1;
                    res_kind_next  = KIND_ACK;
                    res_last_next  = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                emit_kind = res_kind_reg;
                emit_last = res_last_reg;
                if (slot_free) begin
                    emit_en    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RDA: begin
                // The position of the first letter arrives while the second is addressed.
                place_rd_addr = b_reg;
                p1_next       = place_rd;
                state_next    = ST_RDB;
            end
            ST_RDB: begin
                grid_rd_addr = q1_calc;
                q2_next      = q2_calc;
                state_next   = ST_GRA;
            end
            ST_GRA: begin
                grid_rd_addr = q2_reg;
                c1_next      = grid_rd;
                state_next   = ST_GRB;
            end
            ST_GRB: begin
                c2_next    = grid_rd;
                state_next = ST_OUT1;
            end
            ST_OUT1: begin
                emit_letter = c1_reg;
                emit_kind   = KIND_CIPHER;
                if (slot_free) begin
                    emit_en    = 1'b1;
                    state_next = ST_OUT2;
                end
            end
            ST_OUT2: begin
                emit_letter = c2_reg;
                emit_kind   = KIND_CIPHER;
                emit_last   = res_last_reg;
                if (slot_free) begin
                    emit_en    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_letter_next = m_letter_reg;
        m_kind_next   = m_kind_reg;
        m_last_next   = m_last_reg;
        if (emit_en) begin
            m_valid_next  = 1'b1;
            m_letter_next = emit_letter;
            m_kind_next   = emit_kind;
            m_last_next   = emit_last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            count_reg      <= '0;
            key_ready_reg  <= 1'b0;
            pend_reg       <= '0;
            pend_valid_reg <= 1'b0;
            filler_reg     <= LETTER_X;
            pad_reg        <= LETTER_Z;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            count_reg      <= count_next;
            key_ready_reg  <= key_ready_next;
            pend_reg       <= pend_next;
            pend_valid_reg <= pend_valid_next;
            filler_reg     <= filler_next;
            pad_reg        <= pad_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg      <= act_next;
        let_reg      <= let_next;
        walk_reg     <= walk_next;
        b_reg        <= b_next;
        p1_reg       <= p1_next;
        q2_reg       <= q2_next;
        c1_reg       <= c1_next;
        c2_reg       <= c2_next;
        res_kind_reg <= res_kind_next;
        res_last_reg <= res_last_next;
        m_letter_reg <= m_letter_next;
        m_kind_reg   <= m_kind_next;
        m_last_reg   <= m_last_next;
    end
endmodule
